// ===== rtl/lsra_pkg.sv =====
// shared constants and types for the letterbox scale and rotate address unit
package lsra_pkg;

    // default logical landscape area
    localparam int LSRA_AREA_W = 1920;
    localparam int LSRA_AREA_H = 1080;

    // register and field widths
    localparam int CFGW   = 13;
    localparam int PITCHW = 15;
    localparam int INW    = 11;
    localparam int OUTW   = 12;
    localparam int DESTW  = 26;
    // quotient bits per divider: quotient stays below a 13-bit source size
    localparam int QW     = 13;

    // register indexes
    localparam logic [2:0] REG_SRC_W   = 3'd0;
    localparam logic [2:0] REG_SRC_H   = 3'd1;
    localparam logic [2:0] REG_PANEL_W = 3'd2;
    localparam logic [2:0] REG_PANEL_H = 3'd3;
    localparam logic [2:0] REG_PITCH   = 3'd4;

    // register reset values
    localparam logic [CFGW-1:0]   RST_SRC_W   = 13'd1920;
    localparam logic [CFGW-1:0]   RST_SRC_H   = 13'd1080;
    localparam logic [CFGW-1:0]   RST_PANEL_W = 13'd1080;
    localparam logic [CFGW-1:0]   RST_PANEL_H = 13'd1920;
    localparam logic [PITCHW-1:0] RST_PITCH   = 15'd4320;

    // geometry setup sequencer
    typedef enum logic [2:0] {
        SU_INIT,
        SU_DH,
        SU_DW,
        SU_FIN,
        SU_IDLE
    } su_state_t;

endpackage

// ===== rtl/lsra_setup.sv =====
// serial divider sequence that derives scaled size and centering offsets
module lsra_setup #(
    parameter int AREA_WIDTH  = lsra_pkg::LSRA_AREA_W,
    parameter int AREA_HEIGHT = lsra_pkg::LSRA_AREA_H
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [lsra_pkg::CFGW-1:0]              src_width,
    input  logic [lsra_pkg::CFGW-1:0]              src_height,
    output logic                                   busy,
    output logic [$clog2(AREA_WIDTH+1)-1:0]        dw,
    output logic [$clog2(AREA_HEIGHT+1)-1:0]       dh,
    output logic [$clog2(AREA_WIDTH+1)-1:0]        xo,
    output logic [$clog2(AREA_HEIGHT+1)-1:0]       yo
);
    import lsra_pkg::*;

    localparam int AWW = $clog2(AREA_WIDTH + 1);
    localparam int AHW = $clog2(AREA_HEIGHT + 1);
    localparam int MW  = (AWW > AHW) ? AWW : AHW;
    localparam int NW  = CFGW + MW;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [AWW-1:0] AW_C = AWW'(AREA_WIDTH);
    localparam logic [AHW-1:0] AH_C = AHW'(AREA_HEIGHT);

    su_state_t          state_reg, state_next;
    logic [CW-1:0]      cnt_reg;
    logic [NW-1:0]      num_reg;
    logic [CFGW:0]      rem_reg;
    logic [CFGW-1:0]    dvs_reg;
    logic [AWW-1:0]     dw_reg;
    logic [AHW-1:0]     dh_reg;
    logic [AWW-1:0]     xo_reg;
    logic [AHW-1:0]     yo_reg;

    logic               zero_src;
    logic [CFGW+1:0]    rem_shift;
    logic               rem_ge;
    logic               last_step;
    logic               dh_big;

    assign zero_src  = (src_width == '0) || (src_height == '0);
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign rem_ge    = rem_shift >= {2'b00, dvs_reg};
    assign last_step = (cnt_reg == CW'(1));
    // quotient of the height pass, including the bit formed this cycle
    assign dh_big    = {num_reg[NW-2:0], rem_ge} > NW'(AREA_HEIGHT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SU_INIT: state_next = zero_src ? SU_FIN : SU_DH;
            SU_DH:
            begin
                if (last_step)
                    state_next = dh_big ? SU_DW : SU_FIN;
            end
            SU_DW:
            begin
                if (last_step)
                    state_next = SU_FIN;
            end
            SU_FIN:  state_next = SU_IDLE;
            SU_IDLE: state_next = SU_IDLE;
            default: state_next = SU_INIT;
        endcase
        if (start)
            state_next = SU_INIT;
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != SU_IDLE);
        dw   = dw_reg;
        dh   = dh_reg;
        xo   = xo_reg;
        yo   = yo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SU_INIT;
        else
            state_reg <= state_next;
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SU_INIT:
            begin
                cnt_reg <= CW'(NW);
                rem_reg <= '0;
                num_reg <= NW'(src_height * AW_C);
                dvs_reg <= src_width;
                if (zero_src)
                begin
                    dw_reg <= '0;
                    dh_reg <= '0;
                end
            end
            SU_DH, SU_DW:
            begin
                cnt_reg <= cnt_reg - CW'(1);
                rem_reg <= rem_ge ? (CFGW+1)'(rem_shift - {2'b00, dvs_reg})
                                  : rem_shift[CFGW:0];
                num_reg <= {num_reg[NW-2:0], rem_ge};
                if (last_step && state_reg == SU_DH)
                begin
                    // second pass divides width by height
                    cnt_reg <= CW'(NW);
                    rem_reg <= '0;
                    num_reg <= NW'(src_width * AH_C);
                    dvs_reg <= src_height;
                    if (dh_big)
                        dh_reg <= AH_C;
                    else
                    begin
                        dh_reg <= AHW'({num_reg[NW-2:0], rem_ge});
                        dw_reg <= AW_C;
                    end
                end
                if (last_step && state_reg == SU_DW)
                    dw_reg <= AWW'({num_reg[NW-2:0], rem_ge});
            end
            SU_FIN:
            begin
                xo_reg <= AWW'((AW_C - dw_reg) >> 1);
                yo_reg <= AHW'((AH_C - dh_reg) >> 1);
            end
            SU_IDLE:
            begin
                cnt_reg <= cnt_reg;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

// ===== rtl/lsra_div_cell.sv =====
// one restoring division step for both source row and column dividers
module lsra_div_cell #(
    parameter int RW = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [RW-1:0]                 in_col_rem,
    input  logic [lsra_pkg::QW-1:0]       in_col_q,
    input  logic [RW-1:0]                 in_row_rem,
    input  logic [lsra_pkg::QW-1:0]       in_row_q,
    input  logic [lsra_pkg::DESTW-1:0]    in_dest,
    input  logic                          in_ok,
    input  logic [RW-1:0]                 col_dvs,
    input  logic [RW-1:0]                 row_dvs,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [RW-1:0]                 out_col_rem,
    output logic [lsra_pkg::QW-1:0]       out_col_q,
    output logic [RW-1:0]                 out_row_rem,
    output logic [lsra_pkg::QW-1:0]       out_row_q,
    output logic [lsra_pkg::DESTW-1:0]    out_dest,
    output logic                          out_ok
);
    import lsra_pkg::*;

    logic                v_reg;
    logic [RW-1:0]       col_rem_reg, row_rem_reg;
    logic [QW-1:0]       col_q_reg, row_q_reg;
    logic [DESTW-1:0]    dest_reg;
    logic                ok_reg;

    logic [RW-1:0]       col_sh, row_sh;
    logic                col_ge, row_ge;

    // shift in the next numerator bit and try the subtract
    assign col_sh = {in_col_rem[RW-2:0], in_col_q[QW-1]};
    assign row_sh = {in_row_rem[RW-2:0], in_row_q[QW-1]};
    assign col_ge = col_sh >= col_dvs;
    assign row_ge = row_sh >= row_dvs;

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            col_rem_reg <= col_ge ? (col_sh - col_dvs) : col_sh;
            row_rem_reg <= row_ge ? (row_sh - row_dvs) : row_sh;
            col_q_reg   <= {in_col_q[QW-2:0], col_ge};
            row_q_reg   <= {in_row_q[QW-2:0], row_ge};
            dest_reg    <= in_dest;
            ok_reg      <= in_ok;
        end
    end

    assign out_valid   = v_reg;
    assign out_col_rem = col_rem_reg;
    assign out_col_q   = col_q_reg;
    assign out_row_rem = row_rem_reg;
    assign out_row_q   = row_q_reg;
    assign out_dest    = dest_reg;
    assign out_ok      = ok_reg;

endmodule

// ===== rtl/letterbox_scale_rotate_address.sv =====
// top level: registers, entry stage and divider cell chain of the address unit
//
// Input channel in_valid/in_ready carries one position (out_x, out_y) per item;
// output channel out_valid/out_ready returns src_row, src_col, dest_offset and
// write_valid for it, in order. Registers sit on an APB-style port at byte
// addresses 0,4,8,12,16; pready is always high, reads return the register.
// Throughput is one item per clock while out_ready is high and no setup pass
// runs. An entry stage forms the products, range checks and framebuffer
// offset, then a chain of 13 division cells each produce one quotient bit
// of row and column. Each stage holds its item when the next one is full and
// stalled, so a stalled receiver stops every full stage at once; bubbles still
// fill while stalled. After reset, and after each write of src_width or
// src_height, a serial divider recomputes the scaled size and centering
// offsets in up to two passes, with in_ready held low.
// Reset loads the default register values and empties the chain.
module letterbox_scale_rotate_address #(
    parameter int AREA_WIDTH  = lsra_pkg::LSRA_AREA_W,
    parameter int AREA_HEIGHT = lsra_pkg::LSRA_AREA_H
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsra_pkg::INW-1:0]      out_x,
    input  logic [lsra_pkg::INW-1:0]      out_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsra_pkg::OUTW-1:0]     src_row,
    output logic [lsra_pkg::OUTW-1:0]     src_col,
    output logic [lsra_pkg::DESTW-1:0]    dest_offset,
    output logic                          write_valid
);
    import lsra_pkg::*;

    localparam int AWW = $clog2(AREA_WIDTH + 1);
    localparam int AHW = $clog2(AREA_HEIGHT + 1);
    localparam int MW  = (AWW > AHW) ? AWW : AHW;
    localparam int RW  = MW + 1;
    localparam int PW  = ((MW > INW) ? MW : INW) + 1;
    localparam int CMW = (PW > CFGW) ? PW : CFGW;
    localparam int NUMW = INW + CFGW;

    // configuration registers
    logic [CFGW-1:0]   src_w_reg, src_h_reg, panel_w_reg, panel_h_reg;
    logic [PITCHW-1:0] pitch_reg;
    logic              wr_en;
    logic [2:0]        wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= RST_SRC_W;
            src_h_reg   <= RST_SRC_H;
            panel_w_reg <= RST_PANEL_W;
            panel_h_reg <= RST_PANEL_H;
            pitch_reg   <= RST_PITCH;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_SRC_W:   src_w_reg   <= pwdata[CFGW-1:0];
                REG_SRC_H:   src_h_reg   <= pwdata[CFGW-1:0];
                REG_PANEL_W: panel_w_reg <= pwdata[CFGW-1:0];
                REG_PANEL_H: panel_h_reg <= pwdata[CFGW-1:0];
                REG_PITCH:   pitch_reg   <= pwdata[PITCHW-1:0];
                default:     pitch_reg   <= pitch_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (wr_idx)
            REG_SRC_W:   prdata = 32'(src_w_reg);
            REG_SRC_H:   prdata = 32'(src_h_reg);
            REG_PANEL_W: prdata = 32'(panel_w_reg);
            REG_PANEL_H: prdata = 32'(panel_h_reg);
            REG_PITCH:   prdata = 32'(pitch_reg);
            default:     prdata = '0;
        endcase
    end

    // geometry setup
    logic            su_start, su_busy;
    logic [AWW-1:0]  dw, xo;
    logic [AHW-1:0]  dh, yo;

    assign su_start = wr_en && (wr_idx == REG_SRC_W || wr_idx == REG_SRC_H);

    lsra_setup #(
        .AREA_WIDTH  (AREA_WIDTH),
        .AREA_HEIGHT (AREA_HEIGHT)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (su_start),
        .src_width  (src_w_reg),
        .src_height (src_h_reg),
        .busy       (su_busy),
        .dw         (dw),
        .dh         (dh),
        .xo         (xo),
        .yo         (yo)
    );

    // entry stage: range checks, products and framebuffer offset
    logic [PW-1:0]     lx, ly;
    logic [AHW-1:0]    pcol;
    logic              pos_ok;
    logic [DESTW-1:0]  dest_c;

    assign lx   = PW'(xo) + PW'(out_x);
    assign ly   = PW'(yo) + PW'(out_y);
    assign pcol = AHW'(PW'(AREA_HEIGHT - 1) - ly);

    always_comb
    begin
        pos_ok = (dw != '0) && (dh != '0)
              && (MW'(out_x) < MW'(dw)) && (MW'(out_y) < MW'(dh))
              && (ly < PW'(AREA_HEIGHT))
              && (CMW'(pcol) < CMW'(panel_w_reg))
              && (CMW'(lx) < CMW'(panel_h_reg));
        dest_c = DESTW'(lx * pitch_reg) + DESTW'({pcol, 2'b00});
    end

    logic              s0_v_reg;
    logic [NUMW-1:0]   s0_col_num_reg, s0_row_num_reg;
    logic [DESTW-1:0]  s0_dest_reg;
    logic              s0_ok_reg;
    logic              s0_ready;

    assign in_ready = s0_ready && !su_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (s0_ready)
            s0_v_reg <= in_valid && !su_busy;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_col_num_reg <= NUMW'(out_x * src_w_reg);
            s0_row_num_reg <= NUMW'(out_y * src_h_reg);
            s0_dest_reg    <= pos_ok ? dest_c : '0;
            s0_ok_reg      <= pos_ok;
        end
    end

    // divider cell chain
    logic              c_valid [0:QW];
    logic              c_ready [0:QW];
    logic [RW-1:0]     c_col_rem [0:QW];
    logic [RW-1:0]     c_row_rem [0:QW];
    logic [QW-1:0]     c_col_q [0:QW];
    logic [QW-1:0]     c_row_q [0:QW];
    logic [DESTW-1:0]  c_dest [0:QW];
    logic              c_ok [0:QW];

    // numerator high part seeds the remainder, low part is shifted in
    assign c_valid[0]   = s0_v_reg;
    assign s0_ready     = !s0_v_reg || c_ready[0];
    assign c_col_rem[0] = RW'(s0_col_num_reg >> QW);
    assign c_row_rem[0] = RW'(s0_row_num_reg >> QW);
    assign c_col_q[0]   = s0_col_num_reg[QW-1:0];
    assign c_row_q[0]   = s0_row_num_reg[QW-1:0];
    assign c_dest[0]    = s0_dest_reg;
    assign c_ok[0]      = s0_ok_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        lsra_div_cell #(
            .RW (RW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (c_valid[i]),
            .in_ready    (c_ready[i]),
            .in_col_rem  (c_col_rem[i]),
            .in_col_q    (c_col_q[i]),
            .in_row_rem  (c_row_rem[i]),
            .in_row_q    (c_row_q[i]),
            .in_dest     (c_dest[i]),
            .in_ok       (c_ok[i]),
            .col_dvs     (RW'(dw)),
            .row_dvs     (RW'(dh)),
            .out_valid   (c_valid[i+1]),
            .out_ready   (c_ready[i+1]),
            .out_col_rem (c_col_rem[i+1]),
            .out_col_q   (c_col_q[i+1]),
            .out_row_rem (c_row_rem[i+1]),
            .out_row_q   (c_row_q[i+1]),
            .out_dest    (c_dest[i+1]),
            .out_ok      (c_ok[i+1])
        );
    end

    // result
    assign c_ready[QW]  = out_ready;
    assign out_valid    = c_valid[QW];
    assign src_row      = c_ok[QW] ? c_row_q[QW][OUTW-1:0] : '0;
    assign src_col      = c_ok[QW] ? c_col_q[QW][OUTW-1:0] : '0;
    assign dest_offset  = c_dest[QW];
    assign write_valid  = c_ok[QW];

endmodule
